// File: hw/rtl/orsa_pkg.sv
// shared constants, payload types and memory request type of the slot allocator
package orsa_pkg;

  localparam int unsigned SLOTS        = 32;
  localparam int unsigned IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned COUNT_W      = $clog2(SLOTS + 1);
  localparam int unsigned STAMP_W      = 32;
  localparam int unsigned SLOT_FIELD_W = 5;
  localparam int unsigned CMP_W        = (COUNT_W > SLOT_FIELD_W) ? COUNT_W : SLOT_FIELD_W;

  typedef enum logic [1:0] {
    OP_SPAWN   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [SLOT_FIELD_W-1:0] target_slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] chosen_slot;
    logic                    evicted;
    logic                    accepted;
  } rsp_t;

  typedef struct packed {
    logic               mark;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } mem_req_t;

endpackage

// File: hw/rtl/orsa_mem.sv
// slot table memory: active mark and spawn stamp per slot, one read and one write port
module orsa_mem (
  input  logic              clk_i,
  input  orsa_pkg::mem_req_t mem_req_i,
  output orsa_pkg::entry_t   rd_data_o
);
  import orsa_pkg::*;

  entry_t mem_q [SLOTS];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    if (mem_req_i.re) begin
      rd_data_q <= mem_q[mem_req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/orsa_ctrl.sv
// request sequencer: slot scan, oldest-stamp search, read-modify-write and result register
module orsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  orsa_pkg::req_t     req_i,
  output logic               busy_o,
  output logic               done_o,
  output orsa_pkg::rsp_t     rsp_o,
  input  orsa_pkg::entry_t   rd_data_i,
  output orsa_pkg::mem_req_t mem_req_o
);
  import orsa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RMW  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic [COUNT_W-1:0] iss_idx_q, iss_idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [STAMP_W-1:0] lowest_q, lowest_d;
  logic [IDX_W-1:0]   best_q, best_d;
  logic [IDX_W-1:0]   wr_addr_q, wr_addr_d;
  entry_t             wr_entry_q, wr_entry_d;
  logic               append_q, append_d;
  logic               spawn_q, spawn_d;
  logic               evict_q, evict_d;
  logic               done_q, done_d;
  rsp_t               rsp_q, rsp_d;

  logic found, last, better, release_ok;

  // data returned this cycle belongs to the slot read last cycle
  assign found      = cmp_vld_q && !rd_data_i.mark;
  assign last       = cmp_vld_q && ((COUNT_W'(cmp_idx_q) + COUNT_W'(1)) == count_q);
  assign better     = cmp_vld_q && rd_data_i.mark && (rd_data_i.stamp < lowest_q);
  assign release_ok = CMP_W'(req_i.target_slot) < CMP_W'(count_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    stamp_d    = stamp_q;
    iss_idx_d  = iss_idx_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    lowest_d   = lowest_q;
    best_d     = best_q;
    wr_addr_d  = wr_addr_q;
    wr_entry_d = wr_entry_q;
    append_d   = append_q;
    spawn_d    = spawn_q;
    evict_d    = evict_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    mem_req_o  = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (req_i.op)
            OP_SPAWN: begin
              spawn_d   = 1'b1;
              evict_d   = 1'b0;
              iss_idx_d = '0;
              lowest_d  = '1;
              best_d    = '0;
              if (count_q == '0) begin
                wr_addr_d        = '0;
                wr_entry_d.mark  = 1'b1;
                wr_entry_d.stamp = stamp_q;
                append_d         = 1'b1;
                state_d          = ST_FIN;
              end else begin
                append_d = 1'b0;
                state_d  = ST_SCAN;
              end
            end
            OP_RELEASE: begin
              if (release_ok) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = IDX_W'(req_i.target_slot);
                wr_addr_d       = IDX_W'(req_i.target_slot);
                spawn_d         = 1'b0;
                append_d        = 1'b0;
                evict_d         = 1'b0;
                state_d         = ST_RMW;
              end else begin
                rsp_d.chosen_slot = req_i.target_slot;
                rsp_d.evicted     = 1'b0;
                rsp_d.accepted    = 1'b0;
                done_d            = 1'b1;
              end
            end
            OP_CLEAR: begin
              count_d           = '0;
              stamp_d           = '0;
              rsp_d.chosen_slot = '0;
              rsp_d.evicted     = 1'b0;
              rsp_d.accepted    = 1'b1;
              done_d            = 1'b1;
            end
            default: begin
              rsp_d  = '0;
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (found) begin
          wr_addr_d        = cmp_idx_q;
          wr_entry_d.mark  = 1'b1;
          wr_entry_d.stamp = stamp_q;
          state_d          = ST_FIN;
        end else if (last) begin
          if (count_q < COUNT_W'(SLOTS)) begin
            wr_addr_d = IDX_W'(count_q);
            append_d  = 1'b1;
          end else begin
            wr_addr_d = better ? cmp_idx_q : best_q;
            evict_d   = 1'b1;
          end
          wr_entry_d.mark  = 1'b1;
          wr_entry_d.stamp = stamp_q;
          state_d          = ST_FIN;
        end else begin
          if (better) begin
            lowest_d = rd_data_i.stamp;
            best_d   = cmp_idx_q;
          end
          if (iss_idx_q < count_q) begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = iss_idx_q[IDX_W-1:0];
            cmp_vld_d       = 1'b1;
            cmp_idx_d       = iss_idx_q[IDX_W-1:0];
            iss_idx_d       = iss_idx_q + COUNT_W'(1);
          end
        end
      end
      ST_RMW: begin
        wr_entry_d.mark  = 1'b0;
        wr_entry_d.stamp = rd_data_i.stamp;
        state_d          = ST_FIN;
      end
      ST_FIN: begin
        mem_req_o.we      = 1'b1;
        mem_req_o.waddr   = wr_addr_q;
        mem_req_o.wdata   = wr_entry_q;
        rsp_d.chosen_slot = SLOT_FIELD_W'(wr_addr_q);
        rsp_d.evicted     = evict_q;
        rsp_d.accepted    = 1'b1;
        done_d            = 1'b1;
        if (spawn_q) begin
          stamp_d = stamp_q + STAMP_W'(1);
        end
        if (append_q) begin
          count_d = count_q + COUNT_W'(1);
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      stamp_q   <= '0;
      cmp_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      stamp_q   <= stamp_d;
      cmp_vld_q <= cmp_vld_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_idx_q  <= iss_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    lowest_q   <= lowest_d;
    best_q     <= best_d;
    wr_addr_q  <= wr_addr_d;
    wr_entry_q <= wr_entry_d;
    append_q   <= append_d;
    spawn_q    <= spawn_d;
    evict_q    <= evict_d;
    rsp_q      <= rsp_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: hw/rtl/oldest_replacing_slot_allocator.sv
// clear, ignored release and unused op are answered from idle; release reads the
// slot and writes it back; spawn scans to the first free slot or through all used
// slots (none on an empty pool), reading one slot per cycle through the table read port
// the next item is taken in the cycle its predecessor's result shows
// reset: used count and stamp counter go to zero; the slot table is not cleared
// and needs no clearing pass, entries at or above the used count are never read
module oldest_replacing_slot_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  orsa_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output orsa_pkg::rsp_t rsp_o
);
  import orsa_pkg::*;

  // table traffic between sequencer and slot memory
  mem_req_t mem_req;
  entry_t   rd_data;

  // sequencer: spawn scans slots below the used count, one read per cycle,
  // stopping on the first inactive slot while tracking the lowest active stamp;
  // release is a read-modify-write that clears the mark and keeps the stamp
  orsa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_i     (req_i),
    .busy_o    (busy),
    .done_o    (done_o),
    .rsp_o     (rsp_o),
    .rd_data_i (rd_data),
    .mem_req_o (mem_req)
  );

  // slot table, registered read; the sequencer never reads and writes the
  // same cycle, so no forwarding path is needed
  orsa_mem u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rd_data_o (rd_data)
  );

endmodule

// File: hw/rtl/orsa_chk.sv
// port-level checker for the slot allocator and its bind
module orsa_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input orsa_pkg::req_t req_i,
  input orsa_pkg::rsp_t rsp_o
);
  import orsa_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // a result comes only when the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // only a spawn evicts, and a spawn is always accepted
  a_evict_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.evicted) |-> rsp_o.accepted)
    else $error("eviction without acceptance");

  // clear answers in the next cycle with slot zero
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.op == OP_CLEAR) |=>
      (done_o && rsp_o.accepted && !rsp_o.evicted && rsp_o.chosen_slot == '0))
    else $error("clear result wrong");

  // unused op code is answered at once and not accepted
  a_bad_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !(req_i.op == OP_SPAWN || req_i.op == OP_RELEASE ||
                 req_i.op == OP_CLEAR)) |=>
      (done_o && !rsp_o.accepted && !rsp_o.evicted))
    else $error("unused op result wrong");

endmodule

bind oldest_replacing_slot_allocator orsa_chk u_orsa_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);

// File: bench/tb.sv
// testbench of the oldest-replacing slot allocator: directed and random requests
`timescale 1ns / 100ps

module tb;
  import orsa_pkg::*;

  // op code with no operation behind it, the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  // longest item: spawn scanning a full pool, plus margin
  localparam int unsigned SETTLE_CYCLES = SLOTS + 10;
  localparam int unsigned IDLE_PCT = 17;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  logic clk_i;
  logic rst_ni;
  logic start;
  req_t req_i;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  oldest_replacing_slot_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // shadow of the slot pool, updated when an item is accepted
  bit              slot_active [SLOTS];
  bit [STAMP_W-1:0] slot_stamp [SLOTS];
  int unsigned     pool_count;
  bit [STAMP_W-1:0] stamp_next;

  // responses still owed by the block, oldest first
  rsp_t        owed_rsps[$];
  int unsigned mismatches;
  int unsigned cycles;
  // set while the sender must not insert idle cycles
  bit          sender_steady;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic req_t make_req(logic [1:0] op, logic [SLOT_FIELD_W-1:0] target);
    req_t r;
    r.op          = op_e'(op);
    r.target_slot = target;
    return r;
  endfunction

  // expected response of one request; advances the shadow pool state
  function automatic rsp_t allocate_or_release(req_t r);
    rsp_t             o;
    int               pick;
    bit [STAMP_W-1:0] lowest;
    o = '0;
    case (r.op)
      OP_SPAWN: begin
        pick = -1;
        // first free slot among the used ones
        for (int i = 0; i < int'(pool_count); i++) begin
          if (!slot_active[i] && pick < 0) pick = i;
        end
        if (pick < 0 && pool_count < SLOTS) begin
          // room left: append
          pick = int'(pool_count);
          pool_count++;
        end else if (pick < 0) begin
          // full pool, every slot busy: evict the oldest, slot 0 if no stamp is below max
          o.evicted = 1'b1;
          pick      = 0;
          lowest    = '1;
          for (int i = 0; i < int'(SLOTS); i++) begin
            if (slot_active[i] && slot_stamp[i] < lowest) begin
              lowest = slot_stamp[i];
              pick   = i;
            end
          end
        end
        slot_active[pick] = 1'b1;
        slot_stamp[pick]  = stamp_next;
        stamp_next++;
        o.chosen_slot = pick[SLOT_FIELD_W-1:0];
        o.accepted    = 1'b1;
      end
      OP_RELEASE: begin
        // echo the slot; only slots below the used count can be released
        o.chosen_slot = r.target_slot;
        if (int'(r.target_slot) < int'(pool_count)) begin
          slot_active[r.target_slot] = 1'b0;
          o.accepted = 1'b1;
        end
      end
      OP_CLEAR: begin
        // marks and stamps stay, only count and counter restart
        pool_count = 0;
        stamp_next = '0;
        o.accepted = 1'b1;
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic note_mismatch(string field, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES)
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycles, field, want, got);
  endtask

  // response checker: each strobe is compared with the oldest owed response
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (owed_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("unexpected response at cycle %0d: slot %0d evicted %0d accepted %0d",
                   cycles, rsp_o.chosen_slot, rsp_o.evicted, rsp_o.accepted);
      end else begin
        want = owed_rsps.pop_front();
        if (rsp_o.chosen_slot !== want.chosen_slot)
          note_mismatch("chosen_slot", want.chosen_slot, rsp_o.chosen_slot);
        if (rsp_o.evicted !== want.evicted)
          note_mismatch("evicted", want.evicted, rsp_o.evicted);
        if (rsp_o.accepted !== want.accepted)
          note_mismatch("accepted", want.accepted, rsp_o.accepted);
      end
    end
  end

  // present one item and return at the edge that accepts it; start is left high,
  // so the next call either drives a new item or drops start in that same step
  task automatic send_item(req_t r);
    while (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      req_i <= req_t'($urandom);
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    owed_rsps.push_back(allocate_or_release(r));
  endtask

  // stop sending and let every owed response arrive
  task automatic wait_drained();
    start <= 1'b0;
    while (owed_rsps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // random item; spawn_pct steers how fast the pool fills
  function automatic req_t random_req(int unsigned spawn_pct);
    int unsigned roll;
    logic [SLOT_FIELD_W-1:0] target;
    roll   = $urandom_range(99);
    target = SLOT_FIELD_W'($urandom_range(SLOTS - 1));
    if (roll < 2) return make_req(OP_CLEAR, target);
    if (roll < 5) return make_req(OP_UNUSED, target);
    if (roll < 5 + spawn_pct) return make_req(OP_SPAWN, target);
    // releases mostly hit a used slot, sometimes anything
    if (pool_count > 0 && $urandom_range(4) != 0)
      target = SLOT_FIELD_W'($urandom_range(pool_count - 1));
    return make_req(OP_RELEASE, target);
  endfunction

  // each op, ignored releases, reuse of freed slots, unused op, clear
  task automatic test_directed_ops();
    send_item(make_req(OP_SPAWN, 5'd31));     // empty pool: append slot 0
    send_item(make_req(OP_SPAWN, 5'd0));
    send_item(make_req(OP_SPAWN, 5'd21));
    send_item(make_req(OP_RELEASE, 5'd1));
    send_item(make_req(OP_RELEASE, 5'd1));    // already free, still accepted
    send_item(make_req(OP_RELEASE, 5'd3));    // equal to count: ignored
    send_item(make_req(OP_RELEASE, 5'd31));   // far above count: ignored
    send_item(make_req(OP_SPAWN, 5'd10));     // reuses slot 1
    send_item(make_req(OP_RELEASE, 5'd0));
    send_item(make_req(OP_RELEASE, 5'd2));
    send_item(make_req(OP_SPAWN, 5'd0));      // lowest free first
    send_item(make_req(OP_SPAWN, 5'd0));
    send_item(make_req(OP_SPAWN, 5'd0));      // no free slot: append
    send_item(make_req(OP_UNUSED, 5'd31));
    send_item(make_req(OP_UNUSED, 5'd0));
    send_item(make_req(OP_CLEAR, 5'd31));
    send_item(make_req(OP_RELEASE, 5'd0));    // count is zero after clear
    send_item(make_req(OP_SPAWN, 5'd31));     // stamp restarts at zero
    send_item(make_req(OP_CLEAR, 5'd0));
    wait_drained();
  endtask

  // fill all slots, then evict the oldest, mixed with releases of the top slot, slot 5 and random slots
  task automatic test_full_pool_eviction();
    send_item(make_req(OP_CLEAR, 5'd0));
    for (int i = 0; i < int'(SLOTS); i++)
      send_item(make_req(OP_SPAWN, SLOT_FIELD_W'($urandom)));
    for (int i = 0; i < 4; i++)
      send_item(make_req(OP_SPAWN, SLOT_FIELD_W'($urandom)));
    send_item(make_req(OP_RELEASE, SLOT_FIELD_W'(SLOTS - 1)));
    send_item(make_req(OP_RELEASE, 5'd5));
    send_item(make_req(OP_SPAWN, 5'd0));      // reuses slot 5
    send_item(make_req(OP_SPAWN, 5'd0));      // reuses the top slot
    send_item(make_req(OP_SPAWN, 5'd0));      // evicts again
    for (int i = 0; i < 6; i++) begin
      send_item(make_req(OP_RELEASE, SLOT_FIELD_W'($urandom_range(SLOTS - 1))));
      send_item(make_req(OP_SPAWN, SLOT_FIELD_W'($urandom)));
    end
    wait_drained();
  endtask

  // sender holds off until the block has answered everything, then resumes
  task automatic test_sender_pause();
    for (int i = 0; i < 8; i++) send_item(random_req(70));
    wait_drained();
    for (int i = 0; i < 8; i++) send_item(random_req(70));
    wait_drained();
  endtask

  // long random traffic in phases of different spawn pressure
  task automatic test_random_traffic();
    int unsigned spawn_pct;
    spawn_pct = 70;
    for (int n = 0; n < 420; n++) begin
      if (n % 70 == 0) begin
        case ($urandom_range(2))
          0:       spawn_pct = 45;
          1:       spawn_pct = 70;
          default: spawn_pct = 90;
        endcase
      end
      // one long stretch with back-to-back items
      sender_steady = (n >= 150 && n < 240);
      send_item(random_req(spawn_pct));
    end
    sender_steady = 1'b0;
    wait_drained();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_i         = '0;
    pool_count    = 0;
    stamp_next    = '0;
    mismatches    = 0;
    cycles        = 0;
    sender_steady = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ops();
    test_full_pool_eviction();
    test_sender_pause();
    test_random_traffic();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/orsa_pkg.sv
hw/rtl/orsa_mem.sv
hw/rtl/orsa_ctrl.sv
hw/rtl/oldest_replacing_slot_allocator.sv
hw/rtl/orsa_chk.sv
bench/tb.sv
